// File: design/nqbe_pkg.sv
// Shared types and constants for the N-Queens backtracking enumerator.
// Holds the command, status and control-state codes and the attack-mask word.
// No dependencies; every other design file refers to this package by scoped names.
package nqbe_pkg;

  // Width of the board size and of one queen column.
  localparam int SIZE_W = 4;
  localparam int COL_W  = 4;

  // Attack masks cover every column a 4-bit column code can name.
  localparam int MASK_W = 16;

  // Result fields.
  localparam int PLACE_ROWS = 12;
  localparam int PLACE_W    = 48;
  localparam int COUNT_W    = 14;

  // Smallest board size that starts a search.
  localparam int MIN_SIZE = 4;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_FOUND   = 2'd0,
    STAT_DONE    = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_STARTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  // Columns and both diagonals attacked in one row by the queens above it.
  typedef struct packed {
    logic [MASK_W-1:0] cols;
    logic [MASK_W-1:0] ldiag;
    logic [MASK_W-1:0] rdiag;
  } nqbe_masks_t;

endpackage

// File: design/nqbe_in_if.sv
// Request channel interface: valid/ready handshake with the command word.
// Depends on nqbe_pkg for the field widths.
interface nqbe_in_if;
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic [nqbe_pkg::SIZE_W-1:0]     board_side;

  modport source (output valid, output cmd, output board_side, input ready);
  modport sink   (input valid, input cmd, input board_side, output ready);
endinterface

// File: design/nqbe_out_if.sv
// Result channel interface: valid/ready handshake with the result word.
// Depends on nqbe_pkg for the field widths.
interface nqbe_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [nqbe_pkg::PLACE_W-1:0]     placement;
  logic [nqbe_pkg::COUNT_W-1:0]     solution_count;

  modport source (output valid, output status, output placement, output solution_count,
                  input ready);
  modport sink   (input valid, input status, input placement, input solution_count,
                  output ready);
endinterface

// File: design/n_queens_backtrack_enumerator_unit.sv
// Top level of the N-Queens backtracking enumerator: control, search step and result register.
// Instantiates a chain of nqbe_cell rows; uses nqbe_pkg, nqbe_in_if and nqbe_out_if.
//
//   Channel  Direction  Word fields
//   in_ch    sink       cmd, board_side
//   out_ch   source     status, placement, solution_count
//
// A start command, or a next command with no search running, goes from ST_IDLE to ST_RESULT
// and then into the output register. A next command with a search running first passes through
// ST_SEARCH, where each cycle places one queen, backs up one row or finds row 0 exhausted.
// Reset (rst, synchronous) ends any search and clears the size, the count and the channels.
// One word is worked on at a time; a finished result waits in the output register, and the
// next word is taken while it waits, but its own result waits until that one is taken.
module n_queens_backtrack_enumerator_unit #(
  parameter int MAX_N = 12
) (
  input  logic            clk,
  input  logic            rst,
  nqbe_in_if.sink         in_ch,
  nqbe_out_if.source      out_ch
);

  localparam int RW        = $clog2(MAX_N);
  localparam int CW1       = nqbe_pkg::COL_W + 1;
  localparam int PACK_ROWS = (MAX_N < nqbe_pkg::PLACE_ROWS) ? MAX_N : nqbe_pkg::PLACE_ROWS;

  nqbe_pkg::state_t               state;
  nqbe_pkg::state_t               state_next;
  logic [RW-1:0]                  row;
  logic [CW1-1:0]                 col;
  logic                           from_cell;
  logic                           at_solution;
  logic [nqbe_pkg::SIZE_W-1:0]    active_size;
  logic [nqbe_pkg::COUNT_W-1:0]   found_total;
  logic                           live;
  nqbe_pkg::status_t              res_status;

  logic                           out_valid;
  logic [1:0]                     out_status;
  logic [nqbe_pkg::PLACE_W-1:0]   out_placement;
  logic [nqbe_pkg::COUNT_W-1:0]   out_count;

  logic                           in_ready;
  logic                           in_fire;
  logic                           place_en;
  logic                           out_load;

  nqbe_pkg::nqbe_masks_t          cell_masks [MAX_N];
  nqbe_pkg::nqbe_masks_t          down_masks [MAX_N];
  logic [nqbe_pkg::COL_W-1:0]     cell_col   [MAX_N];
  logic                           down_load  [MAX_N];

  nqbe_pkg::nqbe_masks_t          sel_masks;
  logic [nqbe_pkg::COL_W-1:0]     sel_col;
  logic [CW1-1:0]                 col_eff;
  logic [nqbe_pkg::MASK_W-1:0]    cand;
  logic                           hit;
  logic [nqbe_pkg::COL_W-1:0]     pick;
  logic [nqbe_pkg::SIZE_W-1:0]    last_row;
  logic                           is_last;
  logic                           size_ok;
  logic [nqbe_pkg::PLACE_W-1:0]   packed_board;

  // Row cells: cell 0 always sees an empty board above it.
  for (genvar i = 0; i < MAX_N; i++) begin : g_cell
    logic                  up_load_i;
    nqbe_pkg::nqbe_masks_t up_masks_i;
    if (i == 0) begin : g_first
      assign up_load_i  = 1'b1;
      assign up_masks_i = '0;
    end else begin : g_rest
      assign up_load_i  = down_load[i-1];
      assign up_masks_i = down_masks[i-1];
    end
    nqbe_cell u_cell (
      .clk        (clk),
      .up_load    (up_load_i),
      .up_masks   (up_masks_i),
      .place      (place_en && (row == RW'(i))),
      .col_in     (pick),
      .down_load  (down_load[i]),
      .down_masks (down_masks[i]),
      .masks      (cell_masks[i]),
      .column     (cell_col[i])
    );
  end

  // Handshake qualifiers.
  assign in_fire = in_ch.valid && in_ready;
  assign size_ok = (int'(in_ch.board_side) >= nqbe_pkg::MIN_SIZE) &&
                   (int'(in_ch.board_side) <= MAX_N);

  // Search step: lowest free column at or after the start column in the current row.
  assign sel_masks = cell_masks[row];
  assign sel_col   = cell_col[row];
  assign col_eff   = from_cell ? (CW1'(sel_col) + CW1'(1)) : col;
  assign last_row  = active_size - nqbe_pkg::SIZE_W'(1);
  assign is_last   = (nqbe_pkg::SIZE_W'(row) == last_row);

  always_comb begin
    for (int j = 0; j < nqbe_pkg::MASK_W; j++) begin
      cand[j] = !sel_masks.cols[j] && !sel_masks.ldiag[j] && !sel_masks.rdiag[j] &&
                (j < int'(active_size)) && (j >= int'(col_eff));
    end
  end

  always_comb begin
    pick = '0;
    for (int j = nqbe_pkg::MASK_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pick = nqbe_pkg::COL_W'(j);
      end
    end
  end

  assign hit = |cand;

  // Board packing for a found solution; rows beyond the size read as zero.
  always_comb begin
    packed_board = '0;
    for (int r = 0; r < PACK_ROWS; r++) begin
      if (r < int'(active_size)) begin
        packed_board[r*nqbe_pkg::COL_W +: nqbe_pkg::COL_W] = cell_col[r];
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      nqbe_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.cmd == nqbe_pkg::CMD_NEXT && live) begin
            state_next = nqbe_pkg::ST_SEARCH;
          end else begin
            state_next = nqbe_pkg::ST_RESULT;
          end
        end
      end
      nqbe_pkg::ST_SEARCH: begin
        if ((hit && is_last) || (!hit && row == '0)) begin
          state_next = nqbe_pkg::ST_RESULT;
        end
      end
      nqbe_pkg::ST_RESULT: begin
        if (out_load) begin
          state_next = nqbe_pkg::ST_IDLE;
        end
      end
      default: state_next = nqbe_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = 1'b0;
    place_en = 1'b0;
    out_load = 1'b0;
    case (state)
      nqbe_pkg::ST_IDLE:   in_ready = 1'b1;
      nqbe_pkg::ST_SEARCH: place_en = hit;
      nqbe_pkg::ST_RESULT: out_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  // Control state and search registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= nqbe_pkg::ST_IDLE;
      live        <= 1'b0;
      active_size <= '0;
      found_total <= '0;
      at_solution <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (in_ch.cmd == nqbe_pkg::CMD_START) begin
          found_total <= '0;
          at_solution <= 1'b0;
          if (size_ok) begin
            active_size <= in_ch.board_side;
            live        <= 1'b1;
            res_status  <= nqbe_pkg::STAT_STARTED;
          end else begin
            active_size <= '0;
            live        <= 1'b0;
            res_status  <= nqbe_pkg::STAT_INVALID;
          end
        end else if (!live) begin
          res_status <= nqbe_pkg::STAT_DONE;
        end else if (at_solution) begin
          // Resume from the last row of the previous solution, one column further on.
          row       <= last_row[RW-1:0];
          from_cell <= 1'b1;
        end else begin
          row       <= '0;
          col       <= '0;
          from_cell <= 1'b0;
        end
      end else if (state == nqbe_pkg::ST_SEARCH) begin
        if (hit) begin
          if (is_last) begin
            if (found_total != '1) begin
              found_total <= found_total + nqbe_pkg::COUNT_W'(1);
            end
            at_solution <= 1'b1;
            res_status  <= nqbe_pkg::STAT_FOUND;
          end else begin
            row       <= row + RW'(1);
            col       <= '0;
            from_cell <= 1'b0;
          end
        end else if (row == '0) begin
          // Row 0 has no column left: the walk is exhausted.
          live        <= 1'b0;
          at_solution <= 1'b0;
          res_status  <= nqbe_pkg::STAT_DONE;
        end else begin
          row       <= row - RW'(1);
          from_cell <= 1'b1;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status    <= res_status;
      out_placement <= (res_status == nqbe_pkg::STAT_FOUND) ? packed_board : '0;
      out_count     <= found_total;
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.placement      = out_placement;
  assign out_ch.solution_count = out_count;

endmodule

// File: design/nqbe_cell.sv
// One board row of the enumerator chain: its queen column and the attack masks it sees.
// Hands the masks for the row below to its neighbor when a queen is placed here.
// Depends on nqbe_pkg.
module nqbe_cell (
  input  logic                        clk,
  input  logic                        up_load,
  input  nqbe_pkg::nqbe_masks_t       up_masks,
  input  logic                        place,
  input  logic [nqbe_pkg::COL_W-1:0]  col_in,
  output logic                        down_load,
  output nqbe_pkg::nqbe_masks_t       down_masks,
  output nqbe_pkg::nqbe_masks_t       masks,
  output logic [nqbe_pkg::COL_W-1:0]  column
);

  logic [nqbe_pkg::MASK_W-1:0] col_bit;

  // Masks arrive from the row above; the column is written when this row places.
  always_ff @(posedge clk) begin
    if (up_load) begin
      masks <= up_masks;
    end
    if (place) begin
      column <= col_in;
    end
  end

  // One-hot code of the column being placed.
  always_comb begin
    for (int j = 0; j < nqbe_pkg::MASK_W; j++) begin
      col_bit[j] = (nqbe_pkg::COL_W'(j) == col_in);
    end
  end

  // The row below sees this queen in its column and one step along each diagonal.
  always_comb begin
    down_masks.cols  = masks.cols | col_bit;
    down_masks.ldiag = (masks.ldiag | col_bit) << 1;
    down_masks.rdiag = (masks.rdiag | col_bit) >> 1;
    down_load        = place;
  end

endmodule
